// ===== rtl/tssp_pkg.sv =====
// Shared types and constants for the table span slot placer.
// Depends on nothing; every other file refers to it by scoped names.
package tssp_pkg;

    // Fixed field widths of the transfer payloads
    localparam int SPAN_W   = 10;
    localparam int ID_W     = 16;
    localparam int ROWS_W   = 7;
    localparam int RDIDX_W  = 6;

    typedef enum logic [1:0] {
        OP_NEW_ROW = 2'd0,
        OP_PLACE   = 2'd1,
        OP_READ    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_CLIPPED = 2'd1,
        STAT_NO_ROW  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_READ,
        S_RESP
    } state_t;

    // Slot memory port control
    typedef struct packed {
        logic rd;
        logic wr;
        logic occ;
        logic owner_we;
    } mem_ctl_t;

endpackage

// ===== rtl/tssp_cfg_if.sv =====
// Configuration write channel carrying the table row count.
// Depends on tssp_pkg.
interface tssp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tssp_pkg::ROWS_W-1:0]   table_rows;

    modport source (output valid, output table_rows, input ready);
    modport sink   (input valid, input table_rows, output ready);
endinterface

// ===== rtl/tssp_req_if.sv =====
// Request channel: one table operation per transfer.
// Depends on tssp_pkg.
interface tssp_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [tssp_pkg::ID_W-1:0]     cell_id;
    logic                          colspan_given;
    logic [tssp_pkg::SPAN_W-1:0]   colspan_value;
    logic                          rowspan_given;
    logic [tssp_pkg::SPAN_W-1:0]   rowspan_value;
    logic [tssp_pkg::RDIDX_W-1:0]  read_row;
    logic [tssp_pkg::RDIDX_W-1:0]  read_column;

    modport source (output valid, output opcode, output cell_id, output colspan_given,
                    output colspan_value, output rowspan_given, output rowspan_value,
                    output read_row, output read_column, input ready);
    modport sink   (input valid, input opcode, input cell_id, input colspan_given,
                    input colspan_value, input rowspan_given, input rowspan_value,
                    input read_row, input read_column, output ready);
endinterface

// ===== rtl/tssp_rsp_if.sv =====
// Response channel: one result per request.
// Depends on tssp_pkg.
interface tssp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [5:0]                    start_column;
    logic [6:0]                    used_colspan;
    logic [6:0]                    used_rowspan;
    logic                          slot_present;
    logic [tssp_pkg::ID_W-1:0]     slot_cell_id;
    logic [6:0]                    table_width;

    modport source (output valid, output status, output start_column, output used_colspan,
                    output used_rowspan, output slot_present, output slot_cell_id,
                    output table_width, input ready);
    modport sink   (input valid, input status, input start_column, input used_colspan,
                    input used_rowspan, input slot_present, input slot_cell_id,
                    input table_width, output ready);
endinterface

// ===== rtl/tssp_grid.sv =====
// Slot grid memory: occupied bit and owner handle per slot, one port,
// registered read data. Depends on tssp_pkg.
module tssp_grid #(
    parameter int ADDR_W = 12
) (
    input  logic                       clk,
    input  tssp_pkg::mem_ctl_t         ctl,
    input  logic [ADDR_W-1:0]          addr,
    input  logic [tssp_pkg::ID_W-1:0]  wr_owner,
    output logic                       rd_occ,
    output logic [tssp_pkg::ID_W-1:0]  rd_owner
);

    localparam int DEPTH = 1 << ADDR_W;

    logic                      occ_mem   [DEPTH];
    logic [tssp_pkg::ID_W-1:0] owner_mem [DEPTH];
    logic                      rd_occ_reg;
    logic [tssp_pkg::ID_W-1:0] rd_owner_reg;

    // Write one slot, or read one slot into the output register
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            occ_mem[addr] <= ctl.occ;
            if (ctl.owner_we)
            begin
                owner_mem[addr] <= wr_owner;
            end
        end
        if (ctl.rd)
        begin
            rd_occ_reg   <= occ_mem[addr];
            rd_owner_reg <= owner_mem[addr];
        end
    end

    assign rd_occ   = rd_occ_reg;
    assign rd_owner = rd_owner_reg;

endmodule

// ===== rtl/table_span_slot_placer_top.sv =====
// Top level of the table span slot placer: sequencer, cursors and result register.
// Depends on tssp_pkg, tssp_cfg_if, tssp_req_if, tssp_rsp_if and tssp_grid.
//
//   channel | dir | handshake     | payload
//   cfg     | in  | valid/ready   | table_rows
//   req     | in  | valid/ready   | opcode, cell_id, spans, read_row/read_column
//   rsp     | out | valid/ready   | status, start_column, spans, slot data, table_width
//
// New-row goes from idle straight to the result; read slot first reads the slot memory.
// Place cell scans the columns from the cursor on, then writes used_rowspan * used_colspan slots;
// the single slot memory port does one scan read or one slot write per cycle.
// Clear table sweeps every slot (4096 by default), then answers.
// After reset the same sweep runs before req.ready rises; cfg is taken at all times.
// A result held by a stalled rsp lets the next request be accepted and worked on.
module table_span_slot_placer_top #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int SPAN_LIMIT = 1000
) (
    input  logic         clk,
    input  logic         rst_n,
    tssp_cfg_if.sink     cfg,
    tssp_req_if.sink     req,
    tssp_rsp_if.source   rsp
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CR_W   = (RCNT_W > CCNT_W) ? RCNT_W : CCNT_W;
    localparam int WIDE_W = ((CR_W > tssp_pkg::SPAN_W) ? CR_W : tssp_pkg::SPAN_W) + 1;
    localparam int SPAN_W = tssp_pkg::SPAN_W;
    localparam int ID_W   = tssp_pkg::ID_W;

    localparam logic [CCNT_W-1:0] COLS_MAX = CCNT_W'(MAX_COLS);
    localparam logic [CCNT_W-1:0] COL_LAST = CCNT_W'(MAX_COLS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = '1;

    // Control state
    tssp_pkg::state_t          state_reg, state_next;
    logic [tssp_pkg::ROWS_W-1:0] table_rows_reg;
    logic [RCNT_W-1:0]         cur_row_reg, cur_row_next;
    logic                      row_open_reg, row_open_next;
    logic [CCNT_W-1:0]         cur_col_reg, cur_col_next;
    logic [CCNT_W-1:0]         widest_reg, widest_next;
    logic [ADDR_W-1:0]         clr_reg, clr_next;
    logic                      clr_resp_reg, clr_resp_next;
    logic                      out_valid_reg, out_valid_next;

    // Per-item working registers
    logic [CCNT_W-1:0]         col_reg, col_next;
    logic [CCNT_W-1:0]         end_reg, end_next;
    logic                      clip_reg, clip_next;
    logic [ROW_W-1:0]          wr_row_reg, wr_row_next;
    logic [CCNT_W-1:0]         wr_col_reg, wr_col_next;
    logic [RCNT_W-1:0]         rows_left_reg, rows_left_next;
    logic [RCNT_W-1:0]         rowspan_reg, rowspan_next;
    logic [SPAN_W-1:0]         colspan_reg, colspan_next;
    logic [ID_W-1:0]           cid_reg, cid_next;

    // Pending result
    tssp_pkg::status_t         res_status_reg, res_status_next;
    logic [5:0]                res_start_reg, res_start_next;
    logic [6:0]                res_ucol_reg, res_ucol_next;
    logic [6:0]                res_urow_reg, res_urow_next;
    logic                      res_present_reg, res_present_next;
    logic [ID_W-1:0]           res_id_reg, res_id_next;

    // Output register
    tssp_pkg::status_t         out_status_reg;
    logic [5:0]                out_start_reg;
    logic [6:0]                out_ucol_reg;
    logic [6:0]                out_urow_reg;
    logic                      out_present_reg;
    logic [ID_W-1:0]           out_id_reg;
    logic [6:0]                out_width_reg;
    logic                      out_load;

    // Slot memory port
    tssp_pkg::mem_ctl_t        mem_ctl;
    logic [ADDR_W-1:0]         mem_addr;
    logic                      mem_occ;
    logic [ID_W-1:0]           mem_owner;

    // Decode helpers
    tssp_pkg::op_t             op;
    logic [RCNT_W-1:0]         rows;
    logic [RCNT_W-1:0]         remaining;
    logic [WIDE_W-1:0]         next_row_w;
    logic [SPAN_W-1:0]         cval_lim;
    logic [SPAN_W-1:0]         colspan_in;
    logic [RCNT_W-1:0]         rowspan_in;
    logic [WIDE_W-1:0]         end_sum;
    logic                      rd_in_grid;

    tssp_grid #(
        .ADDR_W (ADDR_W)
    ) u_grid (
        .clk      (clk),
        .ctl      (mem_ctl),
        .addr     (mem_addr),
        .wr_owner (cid_reg),
        .rd_occ   (mem_occ),
        .rd_owner (mem_owner)
    );

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_rows_reg <= '0;
        end
        else if (cfg.valid)
        begin
            table_rows_reg <= cfg.table_rows;
        end
    end

    // Span normalization and row bounds
    assign op   = tssp_pkg::op_t'(req.opcode);
    assign rows = (WIDE_W'(table_rows_reg) < WIDE_W'(MAX_ROWS)) ?
                  RCNT_W'(table_rows_reg) : RCNT_W'(MAX_ROWS);
    assign remaining  = rows - cur_row_reg;
    assign next_row_w = WIDE_W'(cur_row_reg) + (row_open_reg ? WIDE_W'(1) : WIDE_W'(0));
    assign cval_lim   = (int'(req.colspan_value) > SPAN_LIMIT) ?
                        SPAN_W'(SPAN_LIMIT) : req.colspan_value;
    assign colspan_in = (req.colspan_given && (cval_lim != '0)) ? cval_lim : SPAN_W'(1);

    always_comb
    begin
        if (!req.rowspan_given)
        begin
            rowspan_in = RCNT_W'(1);
        end
        else if ((req.rowspan_value == '0) ||
                 (WIDE_W'(req.rowspan_value) > WIDE_W'(remaining)))
        begin
            rowspan_in = remaining;
        end
        else
        begin
            rowspan_in = RCNT_W'(req.rowspan_value);
        end
    end

    assign end_sum    = WIDE_W'(col_reg) + WIDE_W'(colspan_reg);
    assign rd_in_grid = (WIDE_W'(req.read_row) < WIDE_W'(MAX_ROWS)) &&
                        (WIDE_W'(req.read_column) < WIDE_W'(MAX_COLS));

    assign req.ready = (state_reg == tssp_pkg::S_IDLE);

    // Sequencer: next state, memory port and register updates
    always_comb
    begin
        state_next       = state_reg;
        cur_row_next     = cur_row_reg;
        row_open_next    = row_open_reg;
        cur_col_next     = cur_col_reg;
        widest_next      = widest_reg;
        clr_next         = clr_reg;
        clr_resp_next    = clr_resp_reg;
        col_next         = col_reg;
        end_next         = end_reg;
        clip_next        = clip_reg;
        wr_row_next      = wr_row_reg;
        wr_col_next      = wr_col_reg;
        rows_left_next   = rows_left_reg;
        rowspan_next     = rowspan_reg;
        colspan_next     = colspan_reg;
        cid_next         = cid_reg;
        res_status_next  = res_status_reg;
        res_start_next   = res_start_reg;
        res_ucol_next    = res_ucol_reg;
        res_urow_next    = res_urow_reg;
        res_present_next = res_present_reg;
        res_id_next      = res_id_reg;
        mem_ctl          = '0;
        mem_addr         = '0;
        out_load         = 1'b0;

        case (state_reg)
            tssp_pkg::S_CLEAR:
            begin
                // Drop one slot per cycle
                mem_ctl.wr = 1'b1;
                mem_addr   = clr_reg;
                clr_next   = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_LAST)
                begin
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? tssp_pkg::S_RESP : tssp_pkg::S_IDLE;
                end
            end

            tssp_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next  = tssp_pkg::STAT_OK;
                    res_start_next   = '0;
                    res_ucol_next    = '0;
                    res_urow_next    = '0;
                    res_present_next = 1'b0;
                    res_id_next      = '0;
                    state_next       = tssp_pkg::S_RESP;
                    case (op)
                        tssp_pkg::OP_NEW_ROW:
                        begin
                            // Advance to the next row, or close past the last one
                            if (next_row_w < WIDE_W'(rows))
                            begin
                                cur_row_next  = RCNT_W'(next_row_w);
                                row_open_next = 1'b1;
                                cur_col_next  = '0;
                            end
                            else
                            begin
                                cur_row_next    = rows;
                                row_open_next   = 1'b0;
                                res_status_next = tssp_pkg::STAT_NO_ROW;
                            end
                        end

                        tssp_pkg::OP_PLACE:
                        begin
                            if (!row_open_reg || (cur_row_reg >= rows))
                            begin
                                res_status_next = tssp_pkg::STAT_NO_ROW;
                            end
                            else
                            begin
                                cid_next     = req.cell_id;
                                colspan_next = colspan_in;
                                rowspan_next = rowspan_in;
                                col_next     = cur_col_reg;
                                if (cur_col_reg >= COLS_MAX)
                                begin
                                    // Row already full from the cursor on
                                    cur_col_next    = COLS_MAX;
                                    res_status_next = tssp_pkg::STAT_CLIPPED;
                                end
                                else
                                begin
                                    mem_ctl.rd = 1'b1;
                                    mem_addr   = {cur_row_reg[ROW_W-1:0],
                                                  cur_col_reg[COL_W-1:0]};
                                    state_next = tssp_pkg::S_SCAN;
                                end
                            end
                        end

                        tssp_pkg::OP_READ:
                        begin
                            if (rd_in_grid)
                            begin
                                mem_ctl.rd = 1'b1;
                                mem_addr   = {ROW_W'(req.read_row), COL_W'(req.read_column)};
                                state_next = tssp_pkg::S_READ;
                            end
                        end

                        tssp_pkg::OP_CLEAR:
                        begin
                            cur_row_next  = '0;
                            row_open_next = 1'b0;
                            cur_col_next  = '0;
                            widest_next   = '0;
                            clr_next      = '0;
                            clr_resp_next = 1'b1;
                            state_next    = tssp_pkg::S_CLEAR;
                        end

                        default:
                        begin
                            state_next = tssp_pkg::S_RESP;
                        end
                    endcase
                end
            end

            tssp_pkg::S_SCAN:
            begin
                // Walk right over occupied slots, one column per cycle
                if (mem_occ)
                begin
                    if (col_reg == COL_LAST)
                    begin
                        cur_col_next    = COLS_MAX;
                        res_status_next = tssp_pkg::STAT_CLIPPED;
                        state_next      = tssp_pkg::S_RESP;
                    end
                    else
                    begin
                        col_next   = col_reg + CCNT_W'(1);
                        mem_ctl.rd = 1'b1;
                        mem_addr   = {cur_row_reg[ROW_W-1:0],
                                      COL_W'(col_reg + CCNT_W'(1))};
                    end
                end
                else
                begin
                    clip_next      = (end_sum > WIDE_W'(MAX_COLS));
                    end_next       = (end_sum > WIDE_W'(MAX_COLS)) ?
                                     COLS_MAX : CCNT_W'(end_sum);
                    wr_row_next    = cur_row_reg[ROW_W-1:0];
                    wr_col_next    = col_reg;
                    rows_left_next = rowspan_reg;
                    state_next     = tssp_pkg::S_WRITE;
                end
            end

            tssp_pkg::S_WRITE:
            begin
                // Fill the covered rectangle row by row
                mem_ctl.wr       = 1'b1;
                mem_ctl.occ      = 1'b1;
                mem_ctl.owner_we = 1'b1;
                mem_addr         = {wr_row_reg, wr_col_reg[COL_W-1:0]};
                if ((wr_col_reg + CCNT_W'(1)) == end_reg)
                begin
                    wr_col_next = col_reg;
                    if (rows_left_reg == RCNT_W'(1))
                    begin
                        cur_col_next = end_reg;
                        if (end_reg > widest_reg)
                        begin
                            widest_next = end_reg;
                        end
                        res_status_next = clip_reg ? tssp_pkg::STAT_CLIPPED : tssp_pkg::STAT_OK;
                        res_start_next  = 6'(col_reg);
                        res_ucol_next   = 7'(end_reg - col_reg);
                        res_urow_next   = 7'(rowspan_reg);
                        state_next      = tssp_pkg::S_RESP;
                    end
                    else
                    begin
                        rows_left_next = rows_left_reg - RCNT_W'(1);
                        wr_row_next    = wr_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    wr_col_next = wr_col_reg + CCNT_W'(1);
                end
            end

            tssp_pkg::S_READ:
            begin
                res_present_next = mem_occ;
                res_id_next      = mem_occ ? mem_owner : '0;
                state_next       = tssp_pkg::S_RESP;
            end

            tssp_pkg::S_RESP:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = tssp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tssp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tssp_pkg::S_CLEAR;
            cur_row_reg   <= '0;
            row_open_reg  <= 1'b0;
            cur_col_reg   <= '0;
            widest_reg    <= '0;
            clr_reg       <= '0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            row_open_reg  <= row_open_next;
            cur_col_reg   <= cur_col_next;
            widest_reg    <= widest_next;
            clr_reg       <= clr_next;
            clr_resp_reg  <= clr_resp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers
    always_ff @(posedge clk)
    begin
        col_reg         <= col_next;
        end_reg         <= end_next;
        clip_reg        <= clip_next;
        wr_row_reg      <= wr_row_next;
        wr_col_reg      <= wr_col_next;
        rows_left_reg   <= rows_left_next;
        rowspan_reg     <= rowspan_next;
        colspan_reg     <= colspan_next;
        cid_reg         <= cid_next;
        res_status_reg  <= res_status_next;
        res_start_reg   <= res_start_next;
        res_ucol_reg    <= res_ucol_next;
        res_urow_reg    <= res_urow_next;
        res_present_reg <= res_present_next;
        res_id_reg      <= res_id_next;
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_start_reg   <= res_start_reg;
            out_ucol_reg    <= res_ucol_reg;
            out_urow_reg    <= res_urow_reg;
            out_present_reg <= res_present_reg;
            out_id_reg      <= res_id_reg;
            out_width_reg   <= 7'(widest_reg);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.start_column = out_start_reg;
    assign rsp.used_colspan = out_ucol_reg;
    assign rsp.used_rowspan = out_urow_reg;
    assign rsp.slot_present = out_present_reg;
    assign rsp.slot_cell_id = out_id_reg;
    assign rsp.table_width  = out_width_reg;

    // A request is worked on alone: the block drops ready right after a transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while previous one still in work");

    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg <= RCNT_W'(MAX_ROWS)) && (cur_col_reg <= COLS_MAX))
        else $error("row or column cursor beyond grid");

    a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
        widest_reg <= COLS_MAX)
        else $error("table width beyond grid");

    a_write_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tssp_pkg::S_WRITE) |-> (wr_col_reg < end_reg) && (wr_col_reg >= col_reg))
        else $error("slot write outside the cell's columns");

    a_no_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == tssp_pkg::STAT_NO_ROW) |->
        (rsp.used_colspan == '0) && (rsp.used_rowspan == '0))
        else $error("no-row result reports placed spans");

endmodule

// ===== dv/table_span_slot_placer_top_tb.sv =====
// Self-checking testbench for table_span_slot_placer_top: directed and random table
// operations, checked against an in-bench model of the slot grid.
// Depends on tssp_pkg, tssp_cfg_if, tssp_req_if, tssp_rsp_if and the RTL top level.
module table_span_slot_placer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_ROWS  = 64;
    localparam int GRID_COLS  = 64;
    localparam int SPAN_CAP   = 1000;
    localparam int GRID_SLOTS = GRID_ROWS * GRID_COLS;
    localparam int SETTLE_CYCLES = 8;
    localparam int ID_W    = tssp_pkg::ID_W;
    localparam int SPAN_W  = tssp_pkg::SPAN_W;
    localparam int RDIDX_W = tssp_pkg::RDIDX_W;
    localparam int ROWS_W  = tssp_pkg::ROWS_W;
    // Worst case: ~650 items, each up to a full 4096-slot write or sweep plus stalls,
    // plus the sweep after reset; taken about four times over.
    localparam int unsigned RUN_LIMIT = 12_000_000;

    typedef struct packed {
        tssp_pkg::op_t       opcode;
        logic [ID_W-1:0]     cell_id;
        logic                colspan_given;
        logic [SPAN_W-1:0]   colspan_value;
        logic                rowspan_given;
        logic [SPAN_W-1:0]   rowspan_value;
        logic [RDIDX_W-1:0]  read_row;
        logic [RDIDX_W-1:0]  read_column;
    } table_req_t;

    typedef struct packed {
        tssp_pkg::status_t   status;
        logic [5:0]          start_column;
        logic [6:0]          used_colspan;
        logic [6:0]          used_rowspan;
        logic                slot_present;
        logic [ID_W-1:0]     slot_cell_id;
        logic [6:0]          table_width;
    } table_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    tssp_cfg_if cfg_ch();
    tssp_req_if req_ch();
    tssp_rsp_if rsp_ch();

    table_span_slot_placer_top #(
        .MAX_ROWS   (GRID_ROWS),
        .MAX_COLS   (GRID_COLS),
        .SPAN_LIMIT (SPAN_CAP)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Grid model state
    bit              slot_taken  [GRID_SLOTS];
    logic [ID_W-1:0] slot_handle [GRID_SLOTS];
    int unsigned     row_cursor;
    int unsigned     col_cursor;
    int unsigned     widest;
    int unsigned     rows_setting;
    bit              row_is_open;

    table_rsp_t  pending_results[$];
    int          error_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned stall_hold;
    int unsigned cycle_count;

    function automatic int unsigned usable_rows();
        return (rows_setting < GRID_ROWS) ? rows_setting : GRID_ROWS;
    endfunction

    function automatic void clear_grid();
        foreach (slot_taken[i])
            slot_taken[i] = 1'b0;
        row_cursor  = 0;
        col_cursor  = 0;
        widest      = 0;
        row_is_open = 1'b0;
    endfunction

    function automatic bit rows_used_up();
        int unsigned next_row;
        next_row = row_is_open ? row_cursor + 1 : row_cursor;
        return next_row >= usable_rows();
    endfunction

    // Advance the grid model by one request and return the result it must produce
    function automatic table_rsp_t predict_result(input table_req_t item);
        table_rsp_t  res;
        int unsigned rows, next_row, col, span_cols, span_rows, left, stop, idx;
        res = '0;
        res.status = tssp_pkg::STAT_OK;
        rows = usable_rows();
        case (item.opcode)
            tssp_pkg::OP_NEW_ROW:
            begin
                next_row = row_is_open ? row_cursor + 1 : row_cursor;
                if (next_row < rows)
                begin
                    row_cursor  = next_row;
                    row_is_open = 1'b1;
                    col_cursor  = 0;
                end
                else
                begin
                    row_cursor  = rows;
                    row_is_open = 1'b0;
                    res.status  = tssp_pkg::STAT_NO_ROW;
                end
            end
            tssp_pkg::OP_PLACE:
            begin
                if (!row_is_open || row_cursor >= rows)
                    res.status = tssp_pkg::STAT_NO_ROW;
                else
                begin
                    // skip columns already claimed by cells from rows above
                    col = col_cursor;
                    while (col < GRID_COLS && slot_taken[row_cursor * GRID_COLS + col])
                        col++;
                    span_cols = 32'(item.colspan_value);
                    if (span_cols > SPAN_CAP)
                        span_cols = SPAN_CAP;
                    if (!item.colspan_given || span_cols == 0)
                        span_cols = 1;
                    left = rows - row_cursor;
                    if (!item.rowspan_given)
                        span_rows = 1;
                    else if (item.rowspan_value == 0 || 32'(item.rowspan_value) > left)
                        span_rows = left;
                    else
                        span_rows = 32'(item.rowspan_value);
                    if (col >= GRID_COLS)
                    begin
                        col_cursor = GRID_COLS;
                        res.status = tssp_pkg::STAT_CLIPPED;
                    end
                    else
                    begin
                        stop = col + span_cols;
                        if (stop > GRID_COLS)
                        begin
                            stop = GRID_COLS;
                            res.status = tssp_pkg::STAT_CLIPPED;
                        end
                        for (int unsigned r = row_cursor; r < row_cursor + span_rows; r++)
                            for (int unsigned c = col; c < stop; c++)
                            begin
                                slot_taken[r * GRID_COLS + c]  = 1'b1;
                                slot_handle[r * GRID_COLS + c] = item.cell_id;
                            end
                        if (widest < stop)
                            widest = stop;
                        col_cursor = stop;
                        res.start_column = 6'(col);
                        res.used_colspan = 7'(stop - col);
                        res.used_rowspan = 7'(span_rows);
                    end
                end
            end
            tssp_pkg::OP_READ:
            begin
                idx = 32'(item.read_row) * GRID_COLS + 32'(item.read_column);
                if (slot_taken[idx])
                begin
                    res.slot_present = 1'b1;
                    res.slot_cell_id = slot_handle[idx];
                end
            end
            tssp_pkg::OP_CLEAR:
                clear_grid();
            default:
                res.status = tssp_pkg::STAT_OK;
        endcase
        res.table_width = 7'(widest);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Record each request transfer and check each result transfer
    always @(posedge clk)
    begin : result_monitor
        table_req_t seen;
        table_rsp_t want;
        if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        begin
            seen.opcode        = tssp_pkg::op_t'(req_ch.opcode);
            seen.cell_id       = req_ch.cell_id;
            seen.colspan_given = req_ch.colspan_given;
            seen.colspan_value = req_ch.colspan_value;
            seen.rowspan_given = req_ch.rowspan_given;
            seen.rowspan_value = req_ch.rowspan_value;
            seen.read_row      = req_ch.read_row;
            seen.read_column   = req_ch.read_column;
            pending_results.push_back(predict_result(seen));
        end
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result with nothing pending: expected none, actual status %0h",
                         $time, rsp_ch.status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status",       32'(want.status),       32'(rsp_ch.status));
                check_field("start_column", 32'(want.start_column), 32'(rsp_ch.start_column));
                check_field("used_colspan", 32'(want.used_colspan), 32'(rsp_ch.used_colspan));
                check_field("used_rowspan", 32'(want.used_rowspan), 32'(rsp_ch.used_rowspan));
                check_field("slot_present", 32'(want.slot_present), 32'(rsp_ch.slot_present));
                check_field("slot_cell_id", 32'(want.slot_cell_id), 32'(rsp_ch.slot_cell_id));
                check_field("table_width",  32'(want.table_width),  32'(rsp_ch.table_width));
            end
        end
    end

    // Drive result ready: a long hold when requested, else random stalls
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_hold = stall_hold - 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // End the run if it hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("table_span_slot_placer_top_tb: errors");
        $finish;
    end

    // All tasks below are entered and left at a falling edge
    task automatic write_table_rows(input logic [ROWS_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.table_rows <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        rows_setting = 32'(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_request(input table_req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= item.opcode;
        req_ch.cell_id       <= item.cell_id;
        req_ch.colspan_given <= item.colspan_given;
        req_ch.colspan_value <= item.colspan_value;
        req_ch.rowspan_given <= item.rowspan_given;
        req_ch.rowspan_value <= item.rowspan_value;
        req_ch.read_row      <= item.read_row;
        req_ch.read_column   <= item.read_column;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // Drop valid and hold until every result is back
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    function automatic table_req_t make_item(input tssp_pkg::op_t op,
                                             input logic [ID_W-1:0] id,
                                             input logic cg, input logic [SPAN_W-1:0] cv,
                                             input logic rg, input logic [SPAN_W-1:0] rv,
                                             input logic [RDIDX_W-1:0] rr,
                                             input logic [RDIDX_W-1:0] rc);
        table_req_t item;
        item.opcode        = op;
        item.cell_id       = id;
        item.colspan_given = cg;
        item.colspan_value = cv;
        item.rowspan_given = rg;
        item.rowspan_value = rv;
        item.read_row      = rr;
        item.read_column   = rc;
        return item;
    endfunction

    function automatic table_req_t random_fields();
        table_req_t item;
        item.opcode        = tssp_pkg::op_t'($urandom_range(0, 3));
        item.cell_id       = ID_W'($urandom_range(0, 65535));
        item.colspan_given = 1'($urandom_range(0, 1));
        item.colspan_value = SPAN_W'($urandom_range(0, 1023));
        item.rowspan_given = 1'($urandom_range(0, 1));
        item.rowspan_value = SPAN_W'($urandom_range(0, 1023));
        item.read_row      = RDIDX_W'($urandom_range(0, 63));
        item.read_column   = RDIDX_W'($urandom_range(0, 63));
        return item;
    endfunction

    // Mostly narrow, short cells; now and then wide, clipped or rows-left spans
    function automatic table_req_t random_cell();
        table_req_t  item;
        int unsigned pick;
        item = random_fields();
        item.opcode = tssp_pkg::OP_PLACE;
        item.colspan_given = ($urandom_range(0, 99) < 80);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            item.colspan_value = SPAN_W'($urandom_range(1, 8));
        else if (pick < 85)
            item.colspan_value = SPAN_W'($urandom_range(9, 64));
        else if (pick < 95)
            item.colspan_value = SPAN_W'($urandom_range(65, 1023));
        else
            item.colspan_value = '0;
        item.rowspan_given = ($urandom_range(0, 99) < 60);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            item.rowspan_value = SPAN_W'($urandom_range(1, 4));
        else if (pick < 85)
            item.rowspan_value = '0;
        else
            item.rowspan_value = SPAN_W'($urandom_range(0, 1023));
        return item;
    endfunction

    // Reset value of the row count: nothing can open
    task automatic test_reset_rows();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h1234, 1'b1, 10'd3, 1'b1, 10'd2,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_NEW_ROW, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        wait_for_results();
    endtask

    // One cell covering the whole grid; this also writes every handle before any read
    task automatic test_full_grid();
        write_table_rows(7'd64);
        send_request(make_item(tssp_pkg::OP_NEW_ROW, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_PLACE, 16'hFFFF, 1'b1, 10'd1023, 1'b1, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_READ, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_READ, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd63, 6'd63));
        send_request(make_item(tssp_pkg::OP_READ, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd21, 6'd42));
        // row already full: nothing written
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_CLEAR, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_READ, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd63, 6'd63));
        wait_for_results();
    endtask

    // Span defaults, clamping, clipping and the free-column scan
    task automatic test_span_rules();
        send_request(make_item(tssp_pkg::OP_NEW_ROW, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h0000, 1'b0, 10'd1023, 1'b0, 10'd1023,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h00A5, 1'b1, 10'd0, 1'b1, 10'd1000,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h5A00, 1'b1, 10'd1000, 1'b1, 10'd1,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_NEW_ROW, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h0001, 1'b1, 10'd1, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h0002, 1'b1, 10'd2, 1'b1, 10'd2,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_READ, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd1, 6'd1));
        send_request(make_item(tssp_pkg::OP_READ, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd2, 6'd3));
        wait_for_results();
    endtask

    // Running out of rows, then widening or shrinking the table under an open cursor
    task automatic test_row_limits();
        write_table_rows(7'd1);
        send_request(make_item(tssp_pkg::OP_CLEAR, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_NEW_ROW, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h0111, 1'b1, 10'd1, 1'b1, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_NEW_ROW, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h0222, 1'b1, 10'd1, 1'b0, 10'd0,
                               6'd0, 6'd0));
        wait_for_results();
        write_table_rows(7'd3);
        send_request(make_item(tssp_pkg::OP_NEW_ROW, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h0333, 1'b1, 10'd2, 1'b1, 10'd5,
                               6'd0, 6'd0));
        wait_for_results();
        write_table_rows(7'd0);
        send_request(make_item(tssp_pkg::OP_NEW_ROW, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        wait_for_results();
        write_table_rows(7'd100);
        send_request(make_item(tssp_pkg::OP_CLEAR, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_NEW_ROW, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_PLACE, 16'h0444, 1'b1, 10'd2, 1'b1, 10'd0,
                               6'd0, 6'd0));
        send_request(make_item(tssp_pkg::OP_READ, 16'h0, 1'b0, 10'd0, 1'b0, 10'd0,
                               6'd63, 6'd1));
        wait_for_results();
    endtask

    // Hold off results for a long stretch while requests keep coming
    task automatic test_backpressure();
        table_req_t item;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_table_rows(7'd64);
        @(posedge clk);
        stall_hold = 400;
        @(negedge clk);
        for (int i = 0; i < 18; i++)
        begin
            item = random_fields();
            if (i % 4 == 0)
                item.opcode = tssp_pkg::OP_NEW_ROW;
            else if (i % 4 == 3)
                item.opcode = tssp_pkg::OP_READ;
            else
            begin
                item.opcode = tssp_pkg::OP_PLACE;
                item.colspan_value = SPAN_W'($urandom_range(1, 3));
                item.rowspan_given = 1'b0;
            end
            send_request(item);
        end
        wait_for_results();
    endtask

    // Well-formed rows of cells and reads, with some noise mixed in
    task automatic test_random_phase(input logic [ROWS_W-1:0] rows, input int unsigned idle_pct,
                                     input int unsigned stall_pct, input int n_items);
        table_req_t  item;
        int          sent;
        int unsigned roll;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_table_rows(rows);
        sent = 0;
        while (sent < n_items)
        begin
            item = random_fields();
            item.opcode = (rows_used_up() && $urandom_range(0, 99) < 60) ?
                          tssp_pkg::OP_CLEAR : tssp_pkg::OP_NEW_ROW;
            send_request(item);
            sent++;
            repeat ($urandom_range(1, 6))
            begin
                roll = $urandom_range(0, 99);
                if (roll < 72)
                    item = random_cell();
                else
                begin
                    item = random_fields();
                    if (roll < 92)
                        item.opcode = tssp_pkg::OP_READ;
                end
                send_request(item);
                sent++;
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.table_rows    = '0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = tssp_pkg::OP_NEW_ROW;
        req_ch.cell_id       = '0;
        req_ch.colspan_given = 1'b0;
        req_ch.colspan_value = '0;
        req_ch.rowspan_given = 1'b0;
        req_ch.rowspan_value = '0;
        req_ch.read_row      = '0;
        req_ch.read_column   = '0;
        rsp_ch.ready         = 1'b0;
        error_count          = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        stall_hold           = 0;
        rows_setting         = 0;
        clear_grid();

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_rows();
        test_full_grid();
        test_span_rules();
        test_row_limits();
        test_backpressure();
        test_random_phase(7'd64, 0, 0, 140);
        test_random_phase(ROWS_W'($urandom_range(1, 64)), 79, 0, 140);
        test_random_phase(7'd127, 0, 79, 140);
        test_random_phase(ROWS_W'($urandom_range(2, 16)), 21, 21, 140);

        wait_for_results();
        if (error_count == 0)
            $display("table_span_slot_placer_top_tb: clean");
        else
            $display("table_span_slot_placer_top_tb: errors");
        $finish;
    end

endmodule
